@@ sv/envpw_pkg.sv @@
package envpw_pkg;

  // Field widths of the request and result items.
  localparam int unsigned ModeW   = 2;
  localparam int unsigned SampleW = 10;
  localparam int unsigned IdxW    = 6;
  localparam int unsigned StatusW = 2;
  localparam int unsigned TickW   = 8;

  // Running average and configuration widths.
  localparam int unsigned AvgW     = 16;
  localparam int unsigned AvgShift = 6;
  localparam int unsigned OffsetW  = 10;
  localparam int unsigned QuietW   = 8;
  localparam int unsigned CfgDataW = 10;
  localparam int unsigned CfgIdxW  = 1;

  // Reset values of the configuration registers.
  localparam logic [OffsetW-1:0] DefThreshold = 10'd50;
  localparam logic [QuietW-1:0]  DefQuiet     = 8'hE0;

  // Default depth of the pulse store.
  localparam int unsigned DefBufDepth = 64;

  // Request kinds.
  typedef enum logic [ModeW-1:0] {
    MODE_SAMPLE  = 2'd0,
    MODE_TICK    = 2'd1,
    MODE_RELEASE = 2'd2,
    MODE_READ    = 2'd3
  } mode_e;

  // Reception status codes.
  typedef enum logic [StatusW-1:0] {
    RX_IDLE      = 2'd0,
    RX_RECEIVING = 2'd1,
    RX_FULL      = 2'd2
  } rx_e;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CFG_THRESHOLD = 1'b0,
    CFG_QUIET     = 1'b1
  } cfg_reg_e;

endpackage

@@ sv/envpw_req_if.sv @@
interface envpw_req_if import envpw_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [ModeW-1:0]   mode;
  logic [SampleW-1:0] sample;
  logic [IdxW-1:0]    index;

  modport source (output valid, output mode, output sample, output index, input ready);
  modport sink (input valid, input mode, input sample, input index, output ready);
endinterface

@@ sv/envpw_res_if.sv @@
interface envpw_res_if import envpw_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               carrier;
  logic [StatusW-1:0] rx_status;
  logic [IdxW-1:0]    pulse_count;
  logic [TickW-1:0]   read_data;

  modport source (output valid, output carrier, output rx_status, output pulse_count,
                  output read_data, input ready);
  modport sink (input valid, input carrier, input rx_status, input pulse_count,
                input read_data, output ready);
endinterface

@@ sv/envelope_pulse_width_capture.sv @@
// Envelope detector with pulse-width capture. Each request is a converter sample, a timer
// tick, a release of the pulse store or a read of one stored entry, and each request gives
// exactly one result carrying the carrier level, the reception status, the write index and,
// for a read, the stored tick count (zero for an index beyond the store). One request is
// taken every clock cycle unless the result side stalls; a request's result is held first
// in stage one, beside the registered read port of the pulse store RAM, and then in the
// output register. A stall on the result side is absorbed by one extra stage, so one
// further request is taken while a result waits. The pulse store is not cleared at reset:
// reading an entry never written since reset returns an arbitrary value. Configuration
// writes take effect at the next edge and should be made while no request is in flight.
module envelope_pulse_width_capture import envpw_pkg::*; #(
  parameter int unsigned BUF_DEPTH = DefBufDepth
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  envpw_req_if.sink           req_i,
  envpw_res_if.source         res_o
);

  localparam int unsigned AW = $clog2(BUF_DEPTH);
  localparam logic [AW-1:0] WiLast = AW'(BUF_DEPTH - 1);

  typedef struct packed {
    logic               carrier;
    logic [StatusW-1:0] rx_status;
    logic [IdxW-1:0]    pulse_count;
    logic               is_read;
  } stage_t;

  // Configuration registers.
  logic [OffsetW-1:0] offset_q;
  logic [QuietW-1:0]  quiet_q;

  // Scalar state.
  logic [AvgW-1:0]  avg_q, avg_d;
  logic [TickW-1:0] ticks_q, ticks_d;
  logic             prev_q, prev_d;
  logic             ign_q, ign_d;
  rx_e              rx_q, rx_d;
  logic [AW-1:0]    wi_q, wi_d;

  // Pipeline.
  logic             s1_valid_q, s1_valid_d;
  stage_t           s1_q, s1_d;
  logic             out_valid_q, out_valid_d;
  stage_t           out_q;
  logic [TickW-1:0] out_data_q;

  logic             acc, move1;
  logic [AvgW-1:0]  avg_dec, avg_new;
  logic [SampleW:0] thr;
  logic             level, quiet_gap, ign_clr;
  logic             ram_we, ram_re;
  logic [TickW-1:0] ram_rdata;
  logic [AW+IdxW-1:0] idx_ext, wi_ext;
  logic             in_range;

  // Handshake: stage one moves on when the output register is free or being emptied.
  assign move1       = s1_valid_q && (!out_valid_q || res_o.ready);
  assign req_i.ready = !s1_valid_q || move1;
  assign acc         = req_i.valid && req_i.ready;

  // Running average and carrier decision.
  assign avg_dec   = avg_q - (avg_q >> AvgShift);
  assign avg_new   = avg_dec + AvgW'(req_i.sample);
  assign thr       = {1'b0, avg_new[AvgW-1:AvgShift]} + {1'b0, offset_q};
  assign level     = {1'b0, req_i.sample} > thr;
  assign quiet_gap = ticks_q > quiet_q;
  assign ign_clr   = quiet_gap ? 1'b0 : ign_q;

  // Read address and range check from the six-bit index.
  assign idx_ext  = {{AW{1'b0}}, req_i.index};
  assign in_range = idx_ext < (AW + IdxW)'(BUF_DEPTH);
  assign wi_ext   = {{IdxW{1'b0}}, wi_q};

  // Next state of the receiver for the request being taken.
  always_comb begin
    avg_d   = avg_q;
    ticks_d = ticks_q;
    prev_d  = prev_q;
    ign_d   = ign_q;
    rx_d    = rx_q;
    wi_d    = wi_q;
    ram_we  = 1'b0;
    ram_re  = 1'b0;
    if (acc) begin
      unique case (mode_e'(req_i.mode))
        MODE_SAMPLE: begin
          avg_d  = avg_new;
          ign_d  = ign_clr;
          prev_d = level;
          unique case (rx_q)
            RX_IDLE: begin
              if (level && !ign_clr) begin
                ticks_d = '0;
                wi_d    = '0;
                rx_d    = RX_RECEIVING;
              end
            end
            RX_FULL: begin
              if (level) begin
                ticks_d = '0;
                ign_d   = 1'b1;
              end
            end
            RX_RECEIVING: begin
              if (level != prev_q) begin
                ram_we  = 1'b1;
                ticks_d = '0;
                if (wi_q != WiLast) begin
                  wi_d = wi_q + 1'b1;
                end
              end else if (quiet_gap) begin
                rx_d = RX_FULL;
              end
            end
            default: begin
              rx_d = rx_q;
            end
          endcase
        end
        MODE_TICK: begin
          ticks_d = ticks_q + 1'b1;
        end
        MODE_RELEASE: begin
          rx_d = RX_IDLE;
        end
        MODE_READ: begin
          ram_re = 1'b1;
        end
        default: begin
          rx_d = rx_q;
        end
      endcase
    end
  end

  // Pulse store.
  envpw_ram #(
    .Width (TickW),
    .Depth (BUF_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wi_q),
    .wdata_i (ticks_q),
    .re_i    (ram_re),
    .raddr_i (idx_ext[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  // Stage one contents for the request being taken.
  always_comb begin
    s1_d.carrier     = prev_d;
    s1_d.rx_status   = rx_d;
    s1_d.pulse_count = IdxW'(wi_d);
    s1_d.is_read     = (mode_e'(req_i.mode) == MODE_READ) && in_range;
  end

  assign s1_valid_d  = acc ? 1'b1 : (move1 ? 1'b0 : s1_valid_q);
  assign out_valid_d = move1 ? 1'b1 : (res_o.ready ? 1'b0 : out_valid_q);

  // Control state and configuration.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q    <= DefThreshold;
      quiet_q     <= DefQuiet;
      avg_q       <= '0;
      ticks_q     <= '0;
      prev_q      <= 1'b0;
      ign_q       <= 1'b0;
      rx_q        <= RX_IDLE;
      wi_q        <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_reg_e'(cfg_index_i) == CFG_THRESHOLD) begin
          offset_q <= cfg_data_i[OffsetW-1:0];
        end else begin
          quiet_q <= cfg_data_i[QuietW-1:0];
        end
      end
      avg_q       <= avg_d;
      ticks_q     <= ticks_d;
      prev_q      <= prev_d;
      ign_q       <= ign_d;
      rx_q        <= rx_d;
      wi_q        <= wi_d;
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers of both stages.
  always_ff @(posedge clk_i) begin
    if (acc) begin
      s1_q <= s1_d;
    end
    if (move1) begin
      out_q      <= s1_q;
      out_data_q <= s1_q.is_read ? ram_rdata : '0;
    end
  end

  assign res_o.valid       = out_valid_q;
  assign res_o.carrier     = out_q.carrier;
  assign res_o.rx_status   = out_q.rx_status;
  assign res_o.pulse_count = out_q.pulse_count;
  assign res_o.read_data   = out_data_q;

  // The write index never runs past the last entry of the store.
  a_wi_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wi_ext <= (AW + IdxW)'(BUF_DEPTH - 1))
    else $error("write index beyond the last store entry");

  // The store is written only while receiving.
  a_we_rx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (rx_q == RX_RECEIVING))
    else $error("store written outside reception");

  // A full pipeline with a stalled result takes no further request.
  a_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && out_valid_q && !res_o.ready) |-> !req_i.ready)
    else $error("request taken while both stages are held");

  // A release always leaves the receiver idle.
  a_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && (mode_e'(req_i.mode) == MODE_RELEASE)) |=> (rx_q == RX_IDLE))
    else $error("release did not return the receiver to idle");

  // The ignore flag is raised only by carrier while the store is full.
  a_ignore: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(ign_q) |-> ($past(rx_q) == RX_FULL))
    else $error("ignore flag raised outside the full state");

endmodule

@@ sv/envpw_ram.sv @@
module envpw_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port and registered read port; the read data holds between reads.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
